// ----- design/tlpq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlpq_pkg
// shared constants, entry and status types for the two level priority queue
// ----------------------------------------------------------------------------
package tlpq_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int ID_W    = 32;
	localparam int AGE_W   = 8;
	localparam int ENTRY_W = ID_W + AGE_W;

	localparam logic [AGE_W-1:0] THRESH_RESET = AGE_W'(60);

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_REJECTED = 2'd1,
		ST_SERVED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// stored entry, age in the low bits
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [AGE_W-1:0] age;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_req_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage
`default_nettype wire

// ----- design/tlpq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlpq_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module tlpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- design/tlpq_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlpq_fifo
// circular fifo: head, tail and fill count around one entry ram
// ----------------------------------------------------------------------------
module tlpq_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tlpq_pkg::fifo_req_t req,
	input  wire tlpq_pkg::entry_t    wr_entry,
	output tlpq_pkg::fifo_stat_t     stat,
	output tlpq_pkg::entry_t         rd_entry
);

	logic [tlpq_pkg::PTR_W-1:0] head_q;
	logic [tlpq_pkg::PTR_W-1:0] tail_q;
	logic [tlpq_pkg::CNT_W-1:0] count_q;
	logic [tlpq_pkg::ENTRY_W-1:0] rdata;

	function automatic logic [tlpq_pkg::PTR_W-1:0] next_ptr(
		input logic [tlpq_pkg::PTR_W-1:0] p
	);
		if (p == tlpq_pkg::PTR_W'(tlpq_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + tlpq_pkg::PTR_W'(1);
	endfunction

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == tlpq_pkg::CNT_W'(tlpq_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (req.push) begin
				tail_q <= next_ptr(tail_q);
			end
			if (req.pop) begin
				head_q <= next_ptr(head_q);
			end
			case ({req.push, req.pop})
				2'b10:   count_q <= count_q + tlpq_pkg::CNT_W'(1);
				2'b01:   count_q <= count_q - tlpq_pkg::CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	tlpq_ram #(
		.WIDTH(tlpq_pkg::ENTRY_W),
		.DEPTH(tlpq_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (req.push),
		.waddr(tail_q),
		.wdata(wr_entry),
		.re   (req.pop),
		.raddr(head_q),
		.rdata(rdata)
	);

	assign rd_entry = rdata;

endmodule
`default_nettype wire

// ----- design/two_level_priority_queue_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_priority_queue_top
// strict priority service over a priority fifo and a normal fifo
// ----------------------------------------------------------------------------
// path: input register, one pass of pointer and count logic, result register
// throughput: one transaction per cycle while the result is not stalled,
//   set by the single ram access per fifo
// reset: both fifos empty, threshold back to 60; ram contents are left as is,
//   only occupied entries are ever read, so no clearing pass is needed
// ----------------------------------------------------------------------------
module two_level_priority_queue_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // [31:0] customer_id, [39:32] age
	input  wire logic        s_tuser,  // [0] kind: 0 enqueue, 1 serve
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,  // [31:0] served_id, [39:32] served_age
	output logic      [2:0]  m_tuser,  // [1:0] status, [2] from_priority
	// threshold register write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data  // [7:0] priority_age_threshold
);

	// threshold register, always writable
	logic [tlpq_pkg::AGE_W-1:0] thresh_q;

	// input stage
	logic                        valid_s1;
	logic                        kind_s1;
	logic [tlpq_pkg::ID_W-1:0]   id_s1;
	logic [tlpq_pkg::AGE_W-1:0]  age_s1;

	// result stage
	logic                        valid_s2;
	tlpq_pkg::status_t           status_s2;
	logic                        prio_s2;

	// fifo control
	tlpq_pkg::fifo_req_t  p_req, n_req;
	tlpq_pkg::fifo_stat_t p_stat, n_stat;
	tlpq_pkg::entry_t     wr_entry, p_rd, n_rd, out_entry;

	// per item decisions
	logic              s2_free;
	logic              fire_s1;
	logic              to_prio;
	logic              tgt_full;
	tlpq_pkg::status_t status_d;
	logic              prio_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= tlpq_pkg::THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	// handshake: the result register frees up when its transaction is taken
	assign s2_free  = !valid_s2 || m_tready;
	assign fire_s1  = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			id_s1   <= s_tdata[31:0];
			age_s1  <= s_tdata[39:32];
		end
	end

	// enqueue routing: age at or above threshold goes to the priority fifo
	assign to_prio  = (age_s1 >= thresh_q);
	assign tgt_full = to_prio ? p_stat.full : n_stat.full;

	assign wr_entry.id  = id_s1;
	assign wr_entry.age = age_s1;

	always_comb begin
		p_req    = '0;
		n_req    = '0;
		status_d = tlpq_pkg::ST_EMPTY;
		prio_d   = 1'b0;
		if (!kind_s1) begin
			// enqueue, a full target drops the entry
			prio_d   = to_prio;
			status_d = tgt_full ? tlpq_pkg::ST_REJECTED : tlpq_pkg::ST_ENQUEUED;
			p_req.push = fire_s1 && to_prio && !tgt_full;
			n_req.push = fire_s1 && !to_prio && !tgt_full;
		end else if (!p_stat.empty) begin
			// serve, priority fifo first
			prio_d    = 1'b1;
			status_d  = tlpq_pkg::ST_SERVED;
			p_req.pop = fire_s1;
		end else if (!n_stat.empty) begin
			status_d  = tlpq_pkg::ST_SERVED;
			n_req.pop = fire_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			status_s2 <= status_d;
			prio_s2   <= prio_d;
		end
	end

	tlpq_fifo u_prio_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (p_req),
		.wr_entry(wr_entry),
		.stat    (p_stat),
		.rd_entry(p_rd)
	);

	tlpq_fifo u_norm_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (n_req),
		.wr_entry(wr_entry),
		.stat    (n_stat),
		.rd_entry(n_rd)
	);

	// ram read data is the served payload; it holds while the result stalls
	always_comb begin
		out_entry = '0;
		if (status_s2 == tlpq_pkg::ST_SERVED) begin
			out_entry = prio_s2 ? p_rd : n_rd;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {out_entry.age, out_entry.id};
	assign m_tuser  = {prio_s2, status_s2};

endmodule
`default_nettype wire

// ----- design/tlpq_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlpq_checker
// port level checks for the two level priority queue, bound to the top level
// ----------------------------------------------------------------------------
module tlpq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [2:0]  m_tuser
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// input back-pressure only comes from a stalled full result path
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	// only a served entry carries data
	a_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] != tlpq_pkg::ST_SERVED |-> m_tdata == '0)
		else $error("data on a result that served nothing");

	// nothing waiting names no fifo
	a_empty_src: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == tlpq_pkg::ST_EMPTY |-> !m_tuser[2])
		else $error("empty serve flagged as priority");

endmodule

bind two_level_priority_queue_top tlpq_checker u_tlpq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
`default_nettype wire
